// ===== rtl/irspt_pkg.sv =====
// ----------------------------------------------------------------------------
// irspt_pkg
// Shared types and constants of the infrared position tracker: field widths,
// command bytes, result kinds, register map and the per-cell control word.
// ----------------------------------------------------------------------------
package irspt_pkg;

  localparam int SENSORS  = 6;
  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 3;
  localparam int CMD_W    = 8;
  localparam int KIND_W   = 2;

  localparam logic [CMD_W-1:0] CMD_RECAL = 8'h43;
  localparam logic [CMD_W-1:0] CMD_GET   = 8'h47;

  localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD    = 2'd2;

  localparam logic [POS_W-1:0] POS_NONE = 3'd0;
  localparam logic [POS_W-1:0] POS_MAX  = 3'd6;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd100;

  // register word index, taken from paddr[2]
  localparam logic REG_DROP_THRESHOLD = 1'b0;

  typedef struct packed {
    logic clear;
    logic finish;
    logic accum;
    logic filter;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,
    JOB_CHECK = 2'd1,
    JOB_GET   = 2'd2,
    JOB_BAD   = 2'd3
  } job_t;

endpackage

// ===== rtl/ir_sensor_position_tracker_unit.sv =====
// A request passes the decision stage, then the result register; an output stall
// can hold it between them. Throughput: one request per cycle while in_stall is
// low; cells update their filters and the priority chain is combinational.
// Reset (rst, synchronous): levels and sums clear, calibration restarts,
// position is 0 and drop_threshold returns to 100.
// ----------------------------------------------------------------------------
// ir_sensor_position_tracker_unit
// Top level: request decode, calibration sequencing, chain of six sensor
// cells, position decision stage, result register and register port.
// ----------------------------------------------------------------------------
module ir_sensor_position_tracker_unit
  import irspt_pkg::*;
#(
  parameter int SAMPLE_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [SAMPLE_W-1:0] sample_0,
  input  logic [SAMPLE_W-1:0] sample_1,
  input  logic [SAMPLE_W-1:0] sample_2,
  input  logic [SAMPLE_W-1:0] sample_3,
  input  logic [SAMPLE_W-1:0] sample_4,
  input  logic [SAMPLE_W-1:0] sample_5,
  input  logic [CMD_W-1:0]    command,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KIND_W-1:0]   kind,
  output logic [POS_W-1:0]    position,
  output logic [CMD_W-1:0]    bad_command,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CNT_W = $clog2(SAMPLE_COUNT);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_COUNT - 1);

  logic [SAMPLE_W-1:0] drop_threshold;
  logic                calibrating;
  logic [CNT_W-1:0]    calib_count;
  logic [POS_W-1:0]    current_position;
  logic                p1_valid;
  job_t                p1_job;
  logic [CMD_W-1:0]    p1_cmd;
  job_t                job_next;
  logic                in_accept;
  logic                out_free;
  logic                advance;
  logic                calib_last;
  cell_ctl_t           ctl;
  logic [SAMPLE_W-1:0] samples [SENSORS];
  logic [POS_W-1:0]    pos_link [SENSORS+1];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DROP_THRESHOLD) ? {20'd0, drop_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DROP_THRESHOLD) begin
      drop_threshold <= pwdata[SAMPLE_W-1:0];
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign advance   = p1_valid && out_free;
  assign in_stall  = p1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign calib_last = (calib_count == CNT_LAST);

  always_comb begin
    ctl      = '0;
    job_next = JOB_NONE;
    if (op) begin
      priority if (command == CMD_RECAL) begin
        ctl.clear = in_accept;
      end else if (command == CMD_GET) begin
        job_next = JOB_GET;
      end else begin
        job_next = JOB_BAD;
      end
    end else if (calibrating) begin
      ctl.finish = in_accept && calib_last;
      ctl.accum  = in_accept && !calib_last;
    end else begin
      ctl.filter = in_accept;
      job_next   = JOB_CHECK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating <= 1'b1;
      calib_count <= '0;
    end else if (ctl.clear) begin
      calibrating <= 1'b1;
      calib_count <= '0;
    end else if (ctl.finish) begin
      calibrating <= 1'b0;
      calib_count <= '0;
    end else if (ctl.accum) begin
      calib_count <= calib_count + CNT_W'(1);
    end
  end

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;
  assign pos_link[SENSORS] = POS_NONE;

  for (genvar i = 0; i < SENSORS; i++) begin : g_cell
    irspt_cell #(
      .SAMPLE_COUNT(SAMPLE_COUNT),
      .INDEX       (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .sample   (samples[i]),
      .threshold(drop_threshold),
      .pos_in   (pos_link[i+1]),
      .pos_out  (pos_link[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (in_accept) begin
      p1_valid <= 1'b1;
    end else if (advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_job <= job_next;
      p1_cmd <= command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      current_position <= POS_NONE;
    end else if (advance) begin
      unique case (p1_job)
        JOB_CHECK: begin
          out_valid <= (pos_link[0] != current_position);
          if (pos_link[0] != current_position) begin
            current_position <= pos_link[0];
          end
        end
        JOB_GET: out_valid <= 1'b1;
        JOB_BAD: out_valid <= 1'b1;
        JOB_NONE: out_valid <= 1'b0;
        default: out_valid <= 1'b0;
      endcase
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      unique case (p1_job)
        JOB_CHECK: begin
          kind        <= KIND_CHANGE;
          position    <= pos_link[0];
          bad_command <= '0;
        end
        JOB_GET: begin
          kind        <= KIND_REPLY;
          position    <= current_position;
          bad_command <= '0;
        end
        JOB_BAD: begin
          kind        <= KIND_BAD;
          position    <= POS_NONE;
          bad_command <= p1_cmd;
        end
        JOB_NONE: ;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register free");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    !calibrating |-> (calib_count == '0))
    else $error("calibration count not clear outside calibration");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    current_position <= POS_MAX)
    else $error("position out of range");

  a_change_updates_position: assert property (@(posedge clk) disable iff (rst)
    (advance && p1_job == JOB_CHECK && pos_link[0] != current_position)
      |=> (current_position == position && out_valid))
    else $error("position change not reported");
`endif

endmodule

// ===== rtl/irspt_cell.sv =====
// ----------------------------------------------------------------------------
// irspt_cell
// One sensor slice: holds the smoothed level, ambient level and calibration
// sum, and passes the priority position on to its lower-numbered neighbour.
// ----------------------------------------------------------------------------
module irspt_cell
  import irspt_pkg::*;
#(
  parameter int SAMPLE_COUNT = 16,
  parameter int INDEX        = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cell_ctl_t           ctl,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] threshold,
  input  logic [POS_W-1:0]    pos_in,
  output logic [POS_W-1:0]    pos_out
);

  localparam int LOG_N  = $clog2(SAMPLE_COUNT);
  localparam int SUM_W  = SAMPLE_W + LOG_N;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int KC     = SUM_W + LOG_N;
  localparam int MC_W   = SUM_W + 2;
  localparam int PC_W   = KC + SAMPLE_W + 2;
  localparam int KF     = DIFF_W + LOG_N;
  localparam int MF_W   = DIFF_W + 2;
  localparam int PF_W   = KF + DIFF_W + 2;
  localparam longint unsigned MC_INT =
    ((64'd1 << KC) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
  localparam longint unsigned MF_INT =
    ((64'd1 << KF) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
  localparam logic [MC_W-1:0]   MC         = MC_W'(MC_INT);
  localparam logic [MF_W-1:0]   MF         = MF_W'(MF_INT);
  localparam logic [DIFF_W-1:0] N_LESS_ONE = DIFF_W'(SAMPLE_COUNT - 1);
  localparam logic [POS_W-1:0]  MY_POS     = POS_W'(INDEX + 1);

  logic [SUM_W-1:0]    calib_sum;
  logic [SUM_W-1:0]    calib_sum_next;
  logic [PC_W-1:0]     mean_prod;
  logic [SAMPLE_W-1:0] mean;
  logic [SAMPLE_W-1:0] smoothed;
  logic [SAMPLE_W-1:0] ambient;
  logic [SAMPLE_W-1:0] smoothed_next;
  logic [DIFF_W-1:0]   step_diff;
  logic [DIFF_W-1:0]   step_mag;
  logic [PF_W-1:0]     step_prod;
  logic [DIFF_W-1:0]   step_q;
  logic [DIFF_W-1:0]   step_delta;
  logic [DIFF_W-1:0]   drop;
  logic                covered;

  // truncated mean by reciprocal multiply, exact over the sum range
  assign calib_sum_next = calib_sum + SUM_W'(sample);
  assign mean_prod      = PC_W'(calib_sum_next) * PC_W'(MC);
  assign mean           = mean_prod[KC +: SAMPLE_W];

  // smoothed + floor((sample - smoothed) / N)
  assign step_diff     = {1'b0, sample} - {1'b0, smoothed};
  assign step_mag      = step_diff[DIFF_W-1] ? (N_LESS_ONE - step_diff) : step_diff;
  assign step_prod     = PF_W'(step_mag) * PF_W'(MF);
  assign step_q        = step_prod[KF +: DIFF_W];
  assign step_delta    = step_diff[DIFF_W-1] ? (DIFF_W'(0) - step_q) : step_q;
  assign smoothed_next = smoothed + step_delta[SAMPLE_W-1:0];

  assign drop    = {1'b0, ambient} - {1'b0, smoothed};
  assign covered = !drop[DIFF_W-1] && (drop[SAMPLE_W-1:0] >= threshold);
  assign pos_out = (pos_in != POS_NONE) ? pos_in : (covered ? MY_POS : POS_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_sum <= '0;
      smoothed  <= '0;
      ambient   <= '0;
    end else begin
      priority if (ctl.clear) begin
        calib_sum <= '0;
      end else if (ctl.finish) begin
        calib_sum <= '0;
        smoothed  <= mean;
        ambient   <= mean;
      end else if (ctl.accum) begin
        calib_sum <= calib_sum_next;
      end else if (ctl.filter) begin
        smoothed  <= smoothed_next;
      end
    end
  end

endmodule
